// ===== sv/josel_pkg.sv =====
`timescale 1ns / 1ps
package josel_pkg;

	localparam int COUNT_W        = 7;
	localparam int STEP_W         = 8;
	localparam int MAX_PEOPLE_DEF = 64;

	typedef enum logic [1:0] {
		JOSEL_IDLE,
		JOSEL_JUDGE,
		JOSEL_SEEK
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // start a new circle from the request word
		logic kill;       // remove the person under the cursor
		logic tally_inc;  // count the person under the cursor and move on
		logic seek;       // move the cursor one seat
		logic emit;       // load the result register
		logic emit_last;  // the loaded word closes the run
		logic emit_bad;   // the loaded word reports an invalid request
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic req_bad;    // request word is invalid under the current step
		logic list;       // removals are listed for the running item
		logic one_left;   // only the survivor remains
		logic tally_hit;  // the person under the cursor is the step-th
		logic next_alive; // the seat after the cursor is occupied
		logic cur_alive;  // the seat under the cursor is occupied
		logic out_free;   // the result register can take a word this cycle
	} status_t;

endpackage

// ===== sv/josel_ifs.sv =====
`timescale 1ns / 1ps
interface josel_req_if;
	logic                           valid;
	logic                           ready;
	logic [josel_pkg::COUNT_W-1:0]  count;
	logic                           list_order;

	modport source (output valid, output count, output list_order, input ready);
	modport sink (input valid, input count, input list_order, output ready);
endinterface

interface josel_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [josel_pkg::COUNT_W-1:0]  position;
	logic                           last;

	modport source (output valid, output position, output last, input ready);
	modport sink (input valid, input position, input last, output ready);
endinterface

// ===== sv/josel_ctrl.sv =====
`timescale 1ns / 1ps
module josel_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  josel_pkg::status_t status,
	output josel_pkg::cmd_t    cmd,
	output josel_pkg::state_t  state
);

	josel_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= josel_pkg::JOSEL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			josel_pkg::JOSEL_IDLE: begin
				// a bad request answers at once with a single closing word
				req_ready = status.out_free;
				if (req_valid && status.out_free) begin
					if (status.req_bad) begin
						cmd.emit      = 1'b1;
						cmd.emit_last = 1'b1;
						cmd.emit_bad  = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = josel_pkg::JOSEL_JUDGE;
					end
				end
			end
			josel_pkg::JOSEL_JUDGE: begin
				if (status.one_left) begin
					if (status.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_last = 1'b1;
						state_d       = josel_pkg::JOSEL_IDLE;
					end
				end else if (status.tally_hit) begin
					// hold the removal while a listed word is still pending
					if (!status.list || status.out_free) begin
						cmd.kill = 1'b1;
						cmd.emit = status.list;
						state_d  = josel_pkg::JOSEL_SEEK;
					end
				end else begin
					cmd.tally_inc = 1'b1;
					state_d       = josel_pkg::JOSEL_SEEK;
				end
			end
			josel_pkg::JOSEL_SEEK: begin
				cmd.seek = 1'b1;
				if (status.next_alive) begin
					state_d = josel_pkg::JOSEL_JUDGE;
				end
			end
			default: begin
				state_d = josel_pkg::JOSEL_IDLE;
			end
		endcase
	end

	assign state = state_q;

endmodule

// ===== sv/josel_dp.sv =====
`timescale 1ns / 1ps
module josel_dp #(
	parameter int MAX_PEOPLE = josel_pkg::MAX_PEOPLE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step_we,
	input  logic [josel_pkg::STEP_W-1:0]   step_data,
	input  logic [josel_pkg::COUNT_W-1:0]  req_count,
	input  logic                           req_list_order,
	input  josel_pkg::cmd_t                cmd,
	output josel_pkg::status_t             status,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic [josel_pkg::COUNT_W-1:0]  rsp_position,
	output logic                           rsp_last
);

	localparam int IDX_W = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1;
	localparam logic [josel_pkg::COUNT_W-1:0] MAX_N = josel_pkg::COUNT_W'(MAX_PEOPLE);

	logic [josel_pkg::STEP_W-1:0]  step_q;
	logic [MAX_PEOPLE-1:0]         alive_q;
	logic [MAX_PEOPLE-1:0]         alive_init;
	logic [IDX_W-1:0]              cursor_q;
	logic [josel_pkg::STEP_W-1:0]  tally_q;
	logic [josel_pkg::COUNT_W-1:0] remaining_q;
	logic [josel_pkg::COUNT_W-1:0] n_q;
	logic                          list_q;
	logic                          out_valid_q;
	logic [josel_pkg::COUNT_W-1:0] out_pos_q;
	logic                          out_last_q;

	logic [josel_pkg::COUNT_W-1:0] cur_p1;
	logic [IDX_W-1:0]              nxt_idx;

	always_comb begin
		for (int i = 0; i < MAX_PEOPLE; i++) begin
			alive_init[i] = josel_pkg::COUNT_W'(i) < req_count;
		end
	end

	// seat after the cursor, wrapping at the circle size
	assign cur_p1  = josel_pkg::COUNT_W'(cursor_q) + 1'b1;
	assign nxt_idx = (cur_p1 >= n_q) ? '0 : cur_p1[IDX_W-1:0];

	always_comb begin
		status            = '0;
		status.req_bad    = (req_count == '0) || (step_q == '0) || (req_count > MAX_N);
		status.list       = list_q;
		status.one_left   = remaining_q == josel_pkg::COUNT_W'(1);
		status.tally_hit  = tally_q == step_q;
		status.next_alive = alive_q[nxt_idx];
		status.cur_alive  = alive_q[cursor_q];
		status.out_free   = !out_valid_q || rsp_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= josel_pkg::STEP_W'(1);
			alive_q     <= '0;
			cursor_q    <= '0;
			tally_q     <= '0;
			remaining_q <= '0;
			n_q         <= '0;
			list_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step_we) begin
				step_q <= step_data;
			end
			if (cmd.load) begin
				alive_q     <= alive_init;
				cursor_q    <= '0;
				tally_q     <= josel_pkg::STEP_W'(1);
				remaining_q <= req_count;
				n_q         <= req_count;
				list_q      <= req_list_order;
			end
			if (cmd.kill) begin
				alive_q[cursor_q] <= 1'b0;
				remaining_q       <= remaining_q - 1'b1;
				tally_q           <= josel_pkg::STEP_W'(1);
			end
			if (cmd.tally_inc) begin
				tally_q <= tally_q + 1'b1;
			end
			if (cmd.seek) begin
				cursor_q <= nxt_idx;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_pos_q  <= cmd.emit_bad ? '0 : cur_p1;
			out_last_q <= cmd.emit_last;
		end
	end

	assign rsp_valid    = out_valid_q;
	assign rsp_position = out_pos_q;
	assign rsp_last     = out_last_q;

endmodule

// ===== sv/josephus_elimination.sv =====
`timescale 1ns / 1ps
// channel  dir  word                      handshake
// req      in   count[6:0], list_order    valid/ready
// rsp      out  position[6:0], last       valid/ready
// step     in   step_data[7:0]            step_we, no ready
//
// One item at a time. Each live person is judged in JUDGE; the cursor then walks
// one seat per cycle in SEEK until it finds the next live seat. A bad request
// answers with a single closing word. Reset clears the controller and the result
// valid flag; step resets to 1. A stalled result holds listed removals, the
// survivor word and the taking of new requests.
module josephus_elimination #(
	parameter int MAX_PEOPLE = josel_pkg::MAX_PEOPLE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step_we,
	input  logic [josel_pkg::STEP_W-1:0] step_data,
	josel_req_if.sink                    req,
	josel_rsp_if.source                  rsp
);

	josel_pkg::cmd_t    cmd;
	josel_pkg::status_t status;
	josel_pkg::state_t  state;

	josel_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd),
		.state     (state)
	);

	josel_dp #(
		.MAX_PEOPLE (MAX_PEOPLE)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_we        (step_we),
		.step_data      (step_data),
		.req_count      (req.count),
		.req_list_order (req.list_order),
		.cmd            (cmd),
		.status         (status),
		.rsp_valid      (rsp.valid),
		.rsp_ready      (rsp.ready),
		.rsp_position   (rsp.position),
		.rsp_last       (rsp.last)
	);

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> state == josel_pkg::JOSEL_IDLE)
		else $error("request taken while an item is running");

	a_judge_live: assert property (@(posedge clk) disable iff (!arst_n)
		state == josel_pkg::JOSEL_JUDGE |-> status.cur_alive)
		else $error("judging an empty seat");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("pending result overwritten");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && cmd.emit_last && state == josel_pkg::JOSEL_JUDGE
		|=> state == josel_pkg::JOSEL_IDLE)
		else $error("survivor word did not end the run");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import josel_pkg::*;

	localparam int WATCHDOG_LIMIT = 300000;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 8;

	typedef struct packed {
		logic [COUNT_W-1:0] position;
		logic               last;
	} word_t;

	typedef enum {PACE_QUIET, PACE_TX_IDLE, PACE_RX_STALL, PACE_BOTH} pace_t;

	// Josephus predictor plus the queue of words still owed by the block
	class josephus_board;
		logic [STEP_W-1:0] step_val;
		word_t             owed_q[$];
		int                errors;
		int                requests;
		int                words_seen;

		function new();
			step_val = 1;
		endfunction

		function void note_request(logic [COUNT_W-1:0] n, logic list);
			logic [63:0]       alive;
			int                cur;
			int                left;
			logic [STEP_W-1:0] tally;
			requests++;
			if (n == 0 || step_val == 0 || n > MAX_PEOPLE_DEF) begin
				owed_q.push_back('{position: '0, last: 1'b1});
				return;
			end
			alive = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
			cur   = 0;
			tally = 1;
			left  = n;
			while (left > 1) begin
				if (tally == step_val) begin
					alive[cur] = 1'b0;
					left--;
					if (list)
						owed_q.push_back('{position: COUNT_W'(cur + 1), last: 1'b0});
					tally = 1;
				end else begin
					tally++;
				end
				// walk to the next live seat
				for (int g = 0; g < 64; g++) begin
					cur = (cur + 1 >= n) ? 0 : cur + 1;
					if (alive[cur])
						break;
				end
			end
			owed_q.push_back('{position: COUNT_W'(cur + 1), last: 1'b1});
		endfunction

		function void check_word(word_t got);
			word_t want;
			words_seen++;
			if (owed_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word position=%0d last=%0b", $time,
					got.position, got.last);
				return;
			end
			want = owed_q.pop_front();
			if (got.position !== want.position) begin
				errors++;
				$display("%0t: position expected %0d actual %0d", $time,
					want.position, got.position);
			end
			if (got.last !== want.last) begin
				errors++;
				$display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
			end
		endfunction

		function void flag_leftovers();
			foreach (owed_q[i]) begin
				errors++;
				$display("%0t: word never arrived, expected position=%0d last=%0b", $time,
					owed_q[i].position, owed_q[i].last);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              step_we;
	logic [STEP_W-1:0] step_data;

	josel_req_if req_ch();
	josel_rsp_if rsp_ch();

	josephus_elimination #(.MAX_PEOPLE(MAX_PEOPLE_DEF)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_we   (step_we),
		.step_data (step_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	josephus_board board;
	int            tx_pct;
	int            rx_pct;
	bit            hold_go;
	int            hold_left;
	int            quiet_cycles;
	int            step_settings;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// response side: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (hold_go) begin
			hold_left = HOLD_CYCLES;
			hold_go   = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (rx_pct != 0 && $urandom_range(99, 0) < rx_pct) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				board.note_request(req_ch.count, req_ch.list_order);
			if (rsp_ch.valid && rsp_ch.ready)
				board.check_word(word_t'({rsp_ch.position, rsp_ch.last}));
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired, %0d words outstanding", $time,
					board.owed_q.size());
				$display("josephus_elimination: mismatch");
				$finish;
			end
		end
	end

	task automatic send(input logic [COUNT_W-1:0] n, input logic list);
		while (tx_pct != 0 && $urandom_range(99, 0) < tx_pct) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		req_ch.valid      <= 1'b1;
		req_ch.count      <= n;
		req_ch.list_order <= list;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (board.owed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_step(input logic [STEP_W-1:0] v);
		drain();
		@(negedge clk);
		step_we   <= 1'b1;
		step_data <= v;
		@(negedge clk);
		step_we <= 1'b0;
		board.step_val = v;
		step_settings++;
		@(posedge clk);
	endtask

	task automatic set_pace(input pace_t mode);
		case (mode)
			PACE_QUIET: begin
				tx_pct = 0;
				rx_pct = 0;
			end
			PACE_TX_IDLE: begin
				tx_pct = 78;
				rx_pct = 0;
			end
			PACE_RX_STALL: begin
				tx_pct = 0;
				rx_pct = 78;
			end
			default: begin
				tx_pct = 6;
				rx_pct = 6;
			end
		endcase
	endtask

	// mostly legal circles; big steps get small circles to bound run time
	function automatic logic [COUNT_W-1:0] pick_count(input logic [STEP_W-1:0] s);
		int r;
		r = $urandom_range(99, 0);
		if (r < 5)
			return '0;
		if (r < 10)
			return COUNT_W'($urandom_range(127, MAX_PEOPLE_DEF + 1));
		if (r < 14 && s <= 32)
			return COUNT_W'(MAX_PEOPLE_DEF);
		return COUNT_W'($urandom_range((s > 32) ? 8 : 20, 1));
	endfunction

	initial begin
		logic [STEP_W-1:0] s;
		board             = new();
		clk               = 1'b0;
		arst_n            = 1'b0;
		step_we           = 1'b0;
		step_data         = '0;
		req_ch.valid      = 1'b0;
		req_ch.count      = '0;
		req_ch.list_order = 1'b0;
		rsp_ch.ready      = 1'b0;
		tx_pct            = 0;
		rx_pct            = 0;
		hold_go           = 1'b0;
		hold_left         = 0;
		quiet_cycles      = 0;
		step_settings     = 1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// step of one after reset: survivor is always the last person
		set_pace(PACE_QUIET);
		send(0, 0);
		send(0, 1);
		send(1, 0);
		send(1, 1);
		send(2, 1);
		send(5, 1);
		send(64, 1);
		send(65, 1);
		send(127, 0);

		// step zero: every request is invalid
		write_step(0);
		send(0, 1);
		send(9, 1);
		send(64, 0);
		send(127, 1);

		write_step(255);
		send(64, 1);
		send(1, 1);
		send(3, 1);
		send(2, 0);

		write_step(2);
		send(7, 1);
		send(41, 0);
		send(64, 1);

		for (int p = 0; p < 8; p++) begin
			s = (p == 2) ? 8'd255 : (p == 5) ? 8'd0 : STEP_W'($urandom_range(12, 1));
			write_step(s);
			set_pace(pace_t'(p % 4));
			if (p == 0)
				hold_go = 1'b1;
			repeat (12) send(pick_count(s), 1'($urandom_range(1, 0)));
		end

		drain();
		board.flag_leftovers();
		$display("covered %0d requests under %0d step settings (0, 1, 2, 255 and random)",
			board.requests, step_settings);
		$display("checked %0d result words across quiet, sender-idle, stall and mixed pacing",
			board.words_seen);
		if (board.errors == 0)
			$display("josephus_elimination: match");
		else
			$display("josephus_elimination: mismatch");
		$finish;
	end
endmodule
